// ===== rtl/tslt_pkg.sv =====
// Shared types and constants for the trailing stop level tracker.
// No dependencies; used by every file of the block.
package tslt_pkg;

  localparam int NUM_ASSETS = 256;
  localparam int SLOT_W     = $clog2(NUM_ASSETS);
  localparam int IDX_W      = 8;
  localparam int PRICE_W    = 32;
  localparam int GAP_W      = 16;
  localparam int PROD_W     = PRICE_W + GAP_W + 1;

  localparam logic [GAP_W-1:0] GAP_RESET = 16'd6554;
  localparam logic [GAP_W:0]   ONE_Q16   = 17'h1_0000;

  typedef struct packed {
    logic [IDX_W-1:0]   asset_index;
    logic [PRICE_W-1:0] price;
    logic               first_sample;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_asset_index;
    logic [PRICE_W-1:0] reference_level;
    logic               sold_flag;
  } out_item_t;

  // price*(1-gap) and price*(1+gap), the latter saturated
  typedef struct packed {
    logic [PRICE_W-1:0] low;
    logic [PRICE_W-1:0] high;
  } band_t;

endpackage

// ===== rtl/tslt_band.sv =====
// Registered band multipliers: price*(1-gap) and saturated price*(1+gap).
// Depends on tslt_pkg.
module tslt_band (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tslt_pkg::PRICE_W-1:0]  price,
  input  logic [tslt_pkg::GAP_W-1:0]    gap,
  output tslt_pkg::band_t               band
);

  logic [tslt_pkg::GAP_W:0]         lo_mul;
  logic [tslt_pkg::GAP_W:0]         hi_mul;
  logic [tslt_pkg::PROD_W-1:0]      lo_prod;
  logic [tslt_pkg::PROD_W-1:0]      hi_prod;
  logic [tslt_pkg::PRICE_W-1:0]     low_r;
  logic [tslt_pkg::PRICE_W:0]       high_r;

  assign lo_mul  = tslt_pkg::ONE_Q16 - {1'b0, gap};
  assign hi_mul  = tslt_pkg::ONE_Q16 + {1'b0, gap};
  assign lo_prod = tslt_pkg::PROD_W'(price) * tslt_pkg::PROD_W'(lo_mul);
  assign hi_prod = tslt_pkg::PROD_W'(price) * tslt_pkg::PROD_W'(hi_mul);

  always_ff @(posedge clk) begin
    if (en) begin
      low_r  <= lo_prod[tslt_pkg::GAP_W +: tslt_pkg::PRICE_W];
      high_r <= hi_prod[tslt_pkg::GAP_W +: (tslt_pkg::PRICE_W + 1)];
    end
  end

  assign band.low  = low_r;
  assign band.high = high_r[tslt_pkg::PRICE_W] ? '1 : high_r[tslt_pkg::PRICE_W-1:0];

endmodule

// ===== rtl/trailing_stop_level_tracker.sv =====
// Top level of the per-asset trailing stop level tracker.
// Depends on tslt_pkg and tslt_band.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one price for one asset.
//   Output channel (out_valid/out_ready/out_data) returns one result per input:
//   the asset index, its new reference level and its sold flag.
//   cfg_we/cfg_wdata write the gap fraction (Q0.16); write only while idle.
// Pipeline: an input transfer loads the update-stage registers, and the
//   result enters the output register when that stage advances. Throughput:
//   one item per cycle while the output is not stalled, set by a single
//   read-modify-write of the level/sold memory per cycle; a write to the
//   slot just read is forwarded to the following item.
// Reset: pipeline and output are emptied, the gap returns to 6554 (about
//   0.10). Store contents are undefined until an asset's first sample.
// Stall: while out_ready is low the output holds its result, one more item
//   is taken into the update stage, and then in_ready drops.
module trailing_stop_level_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tslt_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tslt_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [tslt_pkg::GAP_W-1:0]    cfg_wdata
);

  logic [tslt_pkg::GAP_W-1:0]    gap_r;
  logic                          in_fire;
  logic                          s1_adv;
  logic                          s1_v_r;
  tslt_pkg::in_item_t            s1_item_r;
  tslt_pkg::band_t               band;

  logic [tslt_pkg::PRICE_W-1:0]  level_mem [tslt_pkg::NUM_ASSETS];
  logic                          sold_mem  [tslt_pkg::NUM_ASSETS];
  logic [tslt_pkg::PRICE_W-1:0]  rd_level_r;
  logic                          rd_sold_r;
  logic                          fwd_hit_r;
  logic [tslt_pkg::PRICE_W-1:0]  fwd_level_r;
  logic                          fwd_sold_r;

  logic [tslt_pkg::SLOT_W-1:0]   in_slot;
  logic [tslt_pkg::SLOT_W-1:0]   wr_slot;
  logic [tslt_pkg::PRICE_W-1:0]  cur_level;
  logic                          cur_sold;
  logic [tslt_pkg::PRICE_W-1:0]  new_level;
  logic                          new_sold;

  logic                          out_valid_r;
  tslt_pkg::out_item_t           out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= tslt_pkg::GAP_RESET;
    end else if (cfg_we) begin
      gap_r <= cfg_wdata;
    end
  end

  assign s1_adv   = s1_v_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_v_r | ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign in_slot = in_data.asset_index[tslt_pkg::SLOT_W-1:0];
  assign wr_slot = s1_item_r.asset_index[tslt_pkg::SLOT_W-1:0];

  tslt_band u_band (
    .clk   (clk),
    .en    (in_fire),
    .price (in_data.price),
    .gap   (gap_r),
    .band  (band)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
  end

  // level/sold store: write back from the update stage, read for the new item
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      level_mem[wr_slot] <= new_level;
      sold_mem[wr_slot]  <= new_sold;
    end
    if (in_fire) begin
      rd_level_r <= level_mem[in_slot];
      rd_sold_r  <= sold_mem[in_slot];
    end
  end

  // read returns old data when the same slot is written on that edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_r <= s1_adv & (wr_slot == in_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_level_r <= new_level;
      fwd_sold_r  <= new_sold;
    end
  end

  assign cur_level = fwd_hit_r ? fwd_level_r : rd_level_r;
  assign cur_sold  = fwd_hit_r ? fwd_sold_r  : rd_sold_r;

  always_comb begin
    new_level = cur_level;
    new_sold  = cur_sold;
    if (s1_item_r.first_sample) begin
      new_level = band.low;
      new_sold  = 1'b0;
    end else if (cur_sold) begin
      if (s1_item_r.price > cur_level) begin
        new_level = band.low;
        new_sold  = 1'b0;
      end else if (band.high < cur_level) begin
        new_level = band.high;
      end
    end else begin
      if (s1_item_r.price < cur_level) begin
        new_level = band.high;
        new_sold  = 1'b1;
      end else if (band.low > cur_level) begin
        new_level = band.low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.out_asset_index <= s1_item_r.asset_index;
      out_data_r.reference_level <= new_level;
      out_data_r.sold_flag       <= new_sold;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/tslt_checker.sv =====
// Port-level checks for trailing_stop_level_tracker, attached by bind.
// Depends on tslt_pkg.
module tslt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input tslt_pkg::in_item_t            in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input tslt_pkg::out_item_t           out_data
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input only back-pressures when the output is full and stalled
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // first sample through an empty output: held, level at or below price
  a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.first_sample) ##1 !out_valid |=>
      out_valid && !out_data.sold_flag &&
      out_data.out_asset_index == $past(in_data.asset_index, 2) &&
      out_data.reference_level <= $past(in_data.price, 2))
    else $error("first sample result wrong");

endmodule

bind trailing_stop_level_tracker tslt_checker u_tslt_checker (.*);
